/* rtl/scti_pkg.sv */
package scti_pkg;

  localparam int TABLE_SIZE = 512;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int ADDR_W     = $clog2(TABLE_SIZE + 1);
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 40;
  localparam int POS_W      = FRAC_W + IDX_W;
  localparam int WEIGHT_W   = 30;

  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  // 1/(2*pi) in Q0.32
  localparam logic signed [DATA_W-1:0] INV_TWO_PI   = 32'sd683565276;
  localparam logic [FRAC_W-1:0]        QUARTER_TURN = FRAC_W'(1) << (FRAC_W - 2);
  localparam logic signed [63:0]       ROUND_HALF   = 64'sd1 <<< (WEIGHT_W - 1);
  localparam logic signed [DATA_W-1:0] ONE_Q30      = 32'sd1073741824;
  localparam logic [63:0]              PI_HALF_Q60  = 64'h1921FB54442D1847;

  typedef logic signed [DATA_W-1:0] rom_t [0:TABLE_SIZE];

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
  } phase_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [WEIGHT_W-1:0]      weight;
  } sample_word_t;

  function automatic logic [63:0] mul_q60(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  // restoring long division; divisor is small, so the remainder never overflows
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    int          i;
    rem = 64'd0;
    quo = 64'd0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi/2 * m / n) in Q30, Taylor series in Q60
  function automatic logic signed [DATA_W-1:0] quarter_sine(logic [63:0] m, logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] den;
    int          i;
    int          k;
    if (n == 64'd0 || m >= n) begin
      return ONE_Q30;
    end
    rem = m;
    q   = 64'd0;
    for (i = 0; i < 60; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= n) begin
        rem  = rem - n;
        q[0] = 1'b1;
      end
    end
    x    = mul_q60(q, PI_HALF_Q60);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (k = 1; k <= 13; k++) begin
      den  = 64'((2 * k) * (2 * k + 1));
      term = div_u64(mul_q60(term, x2), den);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << 29)) >> 30;
    if (r > 64'(ONE_Q30)) begin
      r = 64'(ONE_Q30);
    end
    return signed'(r[DATA_W-1:0]);
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] p4;
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] n;
    int          p;
    n = 64'(TABLE_SIZE);
    for (p = 0; p <= TABLE_SIZE; p++) begin
      p4 = 64'(4 * p);
      k  = p4 / TABLE_SIZE;
      m  = p4 - k * n;
      case (k)
        64'd0:   rom[p] = quarter_sine(m, n);
        64'd1:   rom[p] = quarter_sine(n - m, n);
        64'd2:   rom[p] = -quarter_sine(m, n);
        64'd3:   rom[p] = -quarter_sine(n - m, n);
        default: rom[p] = '0;
      endcase
    end
    return rom;
  endfunction

endpackage

/* rtl/scti_phase.sv */
module scti_phase import scti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_angle,
  output logic                     in_stall,
  output logic                     out_valid,
  output phase_word_t              out_word,
  input  logic                     out_stall
);

  logic               s1_v_r;
  logic               s1_cmd_r;
  logic [FRAC_W-1:0]  s1_frac_r;
  logic               s1_en;
  logic               s2_v_r;
  phase_word_t        s2_word_r;
  logic               s2_en;
  logic signed [63:0] turn_prod;
  logic [FRAC_W-1:0]  frac;
  logic [POS_W-1:0]   pos;

  assign s2_en    = !s2_v_r || !out_stall;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;

  // angle in turns, Q8.56; whole turns drop out by keeping the low bits
  assign turn_prod = in_angle * INV_TWO_PI;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_cmd_r  <= in_command;
      s1_frac_r <= turn_prod[55:16];
    end
  end

  assign frac = s1_frac_r + ((s1_cmd_r == CMD_COSINE) ? QUARTER_TURN : '0);
  assign pos  = POS_W'(frac) * POS_W'(TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_word_r.idx    <= pos[POS_W-1:FRAC_W];
      s2_word_r.weight <= pos[FRAC_W-1 -: WEIGHT_W];
    end
  end

  assign out_valid = s2_v_r;
  assign out_word  = s2_word_r;

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_v_r)
    else $error("accepted word did not enter first stage");

endmodule

/* rtl/scti_rom.sv */
module scti_rom import scti_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  phase_word_t  in_word,
  output logic         in_stall,
  output logic         out_valid,
  output sample_word_t out_word,
  input  logic         out_stall
);

  localparam rom_t SinRom = build_rom();

  logic              v_r;
  sample_word_t      word_r;
  logic              en;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;

  assign en       = !v_r || !out_stall;
  assign in_stall = !en;
  assign addr_a   = ADDR_W'(in_word.idx);
  assign addr_b   = addr_a + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  // two read ports, registered read data
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      word_r.a      <= SinRom[addr_a];
      word_r.b      <= SinRom[addr_b];
      word_r.weight <= in_word.weight;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

/* rtl/scti_interp.sv */
module scti_interp import scti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  sample_word_t             in_word,
  output logic                     in_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  input  logic                     out_stall
);

  logic                     s4_v_r;
  logic signed [DATA_W-1:0] s4_a_r;
  logic signed [DATA_W:0]   s4_diff_r;
  logic [WEIGHT_W-1:0]      s4_w_r;
  logic                     s5_v_r;
  logic signed [DATA_W-1:0] s5_a_r;
  logic signed [63:0]       s5_prod_r;
  logic                     s6_v_r;
  logic signed [DATA_W-1:0] s6_value_r;
  logic                     s4_en;
  logic                     s5_en;
  logic                     s6_en;
  logic signed [DATA_W:0]   diff;
  logic signed [WEIGHT_W:0] w_s;
  logic signed [63:0]       prod;
  logic signed [63:0]       t_sum;
  logic signed [63:0]       t_shift;

  assign s6_en    = !s6_v_r || !out_stall;
  assign s5_en    = !s5_v_r || s6_en;
  assign s4_en    = !s4_v_r || s5_en;
  assign in_stall = !s4_en;

  assign diff = {in_word.b[DATA_W-1], in_word.b} - {in_word.a[DATA_W-1], in_word.a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (s4_en) begin
        s4_v_r <= in_valid;
      end
      if (s5_en) begin
        s5_v_r <= s4_v_r;
      end
      if (s6_en) begin
        s6_v_r <= s5_v_r;
      end
    end
  end

  assign w_s  = $signed({1'b0, s4_w_r});
  assign prod = s4_diff_r * w_s;

  // round half up, then floor
  assign t_sum   = s5_prod_r + ROUND_HALF;
  assign t_shift = t_sum >>> WEIGHT_W;

  always_ff @(posedge clk) begin
    if (s4_en && in_valid) begin
      s4_a_r    <= in_word.a;
      s4_diff_r <= diff;
      s4_w_r    <= in_word.weight;
    end
    if (s5_en && s4_v_r) begin
      s5_a_r    <= s4_a_r;
      s5_prod_r <= prod;
    end
    if (s6_en && s5_v_r) begin
      s6_value_r <= s5_a_r + t_shift[DATA_W-1:0];
    end
  end

  assign out_valid = s6_v_r;
  assign out_value = s6_value_r;

endmodule

/* rtl/sine_cosine_table_interpolator_unit.sv */
// Six register stages (scale, position, table read, difference, multiply,
// round) carry an accepted input word to its result on out_value.
// Throughput: one word per clock while out_stall is low.
// A stall holds every full stage and lets empty ones fill.
// Reset (rst_n low, synchronous) clears all stage valid bits; the sine table is constant.
module sine_cosine_table_interpolator_unit import scti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_angle,
  output logic                     in_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  input  logic                     out_stall
);

  logic         ph_valid;
  phase_word_t  ph_word;
  logic         ph_stall;
  logic         rom_valid;
  sample_word_t rom_word;
  logic         rom_stall;

  scti_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_angle   (in_angle),
    .in_stall   (in_stall),
    .out_valid  (ph_valid),
    .out_word   (ph_word),
    .out_stall  (ph_stall)
  );

  scti_rom u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .in_word   (ph_word),
    .in_stall  (ph_stall),
    .out_valid (rom_valid),
    .out_word  (rom_word),
    .out_stall (rom_stall)
  );

  scti_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rom_valid),
    .in_word   (rom_word),
    .in_stall  (rom_stall),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_stall (out_stall)
  );

  // input can only back up when the whole pipe is full and held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free pipeline stage");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value >= -ONE_Q30 && out_value <= ONE_Q30))
    else $error("result outside unit range");

endmodule

/* tb/sine_cosine_table_interpolator_unit_tb.sv */
`timescale 1ns / 100ps

module sine_cosine_table_interpolator_unit_tb;
  import scti_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_WORDS = 1800;

  // 1/(2*pi) in Q0.32, quarter turn in Q56, pi/2 in Q60
  localparam logic signed [63:0] RECIP_TWO_PI = 64'sd683565276;
  localparam logic signed [63:0] QUARTER_Q56  = 64'sd1 <<< 54;
  localparam logic [63:0]        HALF_PI_Q60  = 64'h1921_FB54_442D_1847;
  localparam logic [63:0]        UNIT_Q30     = 64'd1 << 30;

  // angles in Q8.24 radians
  localparam logic signed [31:0] ANG_HALF_PI  = 32'sd26353589;
  localparam logic signed [31:0] ANG_PI       = 32'sd52707179;
  localparam logic signed [31:0] ANG_3HALF_PI = 32'sd79060768;
  localparam logic signed [31:0] ANG_TWO_PI   = 32'sd105414357;

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] angle;
  } angle_word_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_command = CMD_SINE;
  logic signed [DATA_W-1:0] in_angle   = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_stall  = 1'b0;

  logic signed [DATA_W-1:0] sine_rom [0:TABLE_SIZE];
  angle_word_t              angle_words [$];
  logic signed [DATA_W-1:0] value_due [$];
  angle_word_t              next_word;
  logic                     in_taken   = 1'b0;
  logic                     quiet      = 1'b0;
  int                       in_gap     = 0;
  int                       stall_left = 0;
  int unsigned              cycles     = 0;
  int unsigned              err_count  = 0;

  sine_cosine_table_interpolator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_angle   (in_angle),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_stall  (out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] q60_product(logic [63:0] x, logic [63:0] y);
    logic [127:0] wide;
    wide = 128'(x) * 128'(y);
    return wide[123:60];
  endfunction

  // sin(pi/2 * m/n) in Q30 by odd power series in Q60
  function automatic logic signed [DATA_W-1:0] quarter_wave_q30(int unsigned m, int unsigned n);
    logic [127:0] ratio;
    logic [63:0]  x;
    logic [63:0]  x_sq;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [63:0]  rounded;
    int           j;
    if (m >= n) begin
      return DATA_W'(UNIT_Q30);
    end
    ratio = (128'(m) << 60) / 128'(n);
    x     = q60_product(ratio[63:0], HALF_PI_Q60);
    x_sq  = q60_product(x, x);
    term  = x;
    acc   = x;
    for (j = 1; j <= 13; j++) begin
      term = q60_product(term, x_sq) / 64'((2 * j) * (2 * j + 1));
      acc  = (j % 2 == 1) ? acc - term : acc + term;
    end
    rounded = (acc + (64'd1 << 29)) >> 30;
    if (rounded > UNIT_Q30) begin
      rounded = UNIT_Q30;
    end
    return rounded[DATA_W-1:0];
  endfunction

  task automatic fill_sine_rom();
    int unsigned p;
    int unsigned quad;
    int unsigned m;
    for (p = 0; p <= TABLE_SIZE; p++) begin
      quad = (4 * p) / TABLE_SIZE;
      m    = 4 * p - quad * TABLE_SIZE;
      case (quad)
        0:       sine_rom[p] = quarter_wave_q30(m, TABLE_SIZE);
        1:       sine_rom[p] = quarter_wave_q30(TABLE_SIZE - m, TABLE_SIZE);
        2:       sine_rom[p] = -quarter_wave_q30(m, TABLE_SIZE);
        3:       sine_rom[p] = -quarter_wave_q30(TABLE_SIZE - m, TABLE_SIZE);
        default: sine_rom[p] = '0;
      endcase
    end
  endtask

  function automatic logic signed [DATA_W-1:0] sincos_value(logic cmd,
                                                            logic signed [DATA_W-1:0] ang);
    logic signed [63:0] turns;
    logic [63:0]        pos;
    logic [63:0]        idx;
    logic [29:0]        w;
    logic signed [63:0] lo_s;
    logic signed [63:0] hi_s;
    logic signed [63:0] acc;
    logic signed [63:0] res;
    turns = $signed({{32{ang[31]}}, ang}) * RECIP_TWO_PI;
    if (cmd == CMD_COSINE) begin
      turns = turns + QUARTER_Q56;
    end
    // floor to a turn fraction, keep Q0.40
    pos = 64'(turns[55:16]) * 64'(TABLE_SIZE);
    idx = pos >> 40;
    if (idx >= 64'(TABLE_SIZE)) begin
      idx = 64'(TABLE_SIZE - 1);
    end
    w    = pos[39:10];
    lo_s = sine_rom[idx];
    hi_s = sine_rom[idx + 1];
    acc  = (hi_s - lo_s) * $signed({34'd0, w}) + (64'sd1 <<< 29);
    res  = lo_s + (acc >>> 30);
    return res[DATA_W-1:0];
  endfunction

  // mostly short pauses, a few long ones, none in quiet stretches
  function automatic int pick_pause(logic calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(logic cmd, logic signed [DATA_W-1:0] ang);
    angle_word_t wd;
    wd.command = cmd;
    wd.angle   = ang;
    angle_words.push_back(wd);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[7:0] == 8'd0) begin
      quiet <= ($urandom_range(0, 3) == 0);
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("sine_cosine_table_interpolator_unit_tb: done, errors");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0 || angle_words.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) begin
            in_gap <= in_gap - 1;
          end
        end else begin
          next_word = angle_words.pop_front();
          in_valid   <= 1'b1;
          in_command <= next_word.command;
          in_angle   <= next_word.angle;
          in_gap     <= pick_pause(quiet);
        end
      end
    end
  end

  // result-side stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_left = pick_pause(quiet);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
        end
      end
    end
  end

  // accept tracking, prediction and result check
  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        value_due.push_back(sincos_value(in_command, in_angle));
      end
      if (out_valid && !out_stall) begin
        if (value_due.size() == 0) begin
          $error("out_value: no word expected, got %0d", out_value);
          err_count <= err_count + 1;
        end else begin
          want = value_due.pop_front();
          if (out_value !== want) begin
            $error("out_value: expected %0d, got %0d", want, out_value);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

  initial begin
    int          i;
    int          mode;
    logic [31:0] raw;
    fill_sine_rom();

    // directed: zero, extremes, quadrant points, both commands
    for (i = 0; i < 2; i++) begin
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, 32'sd0);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, 32'sh7FFF_FFFF);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, 32'sh8000_0000);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, -32'sd1);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, 32'sd1);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, ANG_HALF_PI);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, -ANG_HALF_PI);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, ANG_PI);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, ANG_3HALF_PI);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, -ANG_TWO_PI);
      add_word(i == 0 ? CMD_SINE : CMD_COSINE, ANG_TWO_PI);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      mode = $urandom_range(0, 9);
      raw  = $urandom;
      if (mode < 4) begin
        add_word(raw[31], $signed($urandom));
      end else if (mode < 8) begin
        // within about +/-8 rad, where most real phases live
        add_word(raw[31], $signed(32'($urandom_range(0, (1 << 28) - 1))) - 32'sd134217728);
      end else if (mode == 8) begin
        add_word(raw[31], $signed({16'h7FFF, raw[15:0]}));
      end else begin
        add_word(raw[31], $signed({16'h8000, raw[15:0]}));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (angle_words.size() != 0 || in_valid) @(posedge clk);
    while (value_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (value_due.size() != 0) begin
      $error("out_value: %0d words never arrived", value_due.size());
    end
    if (err_count == 0 && value_due.size() == 0) begin
      $display("sine_cosine_table_interpolator_unit_tb: done, clean");
    end else begin
      $display("sine_cosine_table_interpolator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
